/* hw/rtl/khi_pkg.sv */
package khi_pkg;

    localparam int KF_MAX    = 64;
    localparam int KF_CNT_W  = $clog2(KF_MAX + 1);
    localparam int KF_IDX_W  = $clog2(KF_MAX);
    localparam int NUM_CH    = 7;
    localparam int CH_IDX_W  = $clog2(NUM_CH);
    localparam int CH_ROT0   = 4;
    localparam int DIV_NUM_W = 57;
    localparam int DIV_QUO_W = 58;
    localparam int DIV_DEN_W = 16;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    localparam logic [1:0] ACT_NOP    = 2'd3;

    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_HELD   = 2'd1;
    localparam logic [1:0] ST_INTERP = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [15:0]        frame_number;
        logic signed [31:0] fov_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] rot_pitch;
        logic signed [31:0] rot_yaw;
        logic signed [31:0] rot_roll;
    } khi_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_fov;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic [15:0]        out_pitch;
        logic [15:0]        out_yaw;
        logic [15:0]        out_roll;
    } khi_out_t;

    typedef struct packed {
        logic [15:0]                  frame;
        logic [NUM_CH-1:0][31:0]      ch;
    } khi_entry_t;

    typedef enum logic {
        DIV_T,
        DIV_SIDE
    } khi_div_src_t;

    typedef enum logic {
        SIDE_A,
        SIDE_D
    } khi_side_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_HOLD_RD,
        S_HOLD_WR,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_LD_RD,
        S_LD_WR,
        S_T_DIV,
        S_T_WAIT,
        S_BAS_T2,
        S_BAS_T3,
        S_BAS_H,
        S_A_MUL,
        S_A_DIV,
        S_A_WAIT,
        S_D_MUL,
        S_D_DIV,
        S_D_WAIT,
        S_M_CALC,
        S_MAC_MUL,
        S_MAC_ACC,
        S_CH_STORE,
        S_FINISH
    } khi_state_t;

    typedef struct packed {
        logic         capture;
        logic         clear;
        logic         append;
        logic         rd_last;
        logic         rd_idx;
        logic         idx_init;
        logic         idx_dec;
        logic         ld_init;
        logic         ld_rd;
        logic         ld_wr;
        logic         div_start;
        khi_div_src_t div_src;
        khi_side_t    side;
        logic         side_mul;
        logic         q_load;
        logic         t_load;
        logic         t2_load;
        logic         t3_load;
        logic         h_load;
        logic         ch_init;
        logic         m_load;
        logic         mac_clr;
        logic         mac_mul;
        logic         mac_acc;
        logic         ch_store;
        logic         ch_next;
        logic         res_zero;
        logic         res_hold;
        logic         out_load;
    } khi_cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic       q_zero;
        logic       q_hold;
        logic       idx_stop;
        logic       ld_last;
        logic       has_prev;
        logic       has_next;
        logic       div_done;
        logic       mac_last;
        logic       ch_last;
        logic       out_free;
    } khi_stat_t;

endpackage

/* hw/rtl/khi_divider.sv */
module khi_divider (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [khi_pkg::DIV_NUM_W-1:0]         num_mag,
    input  logic                                  neg,
    input  logic [khi_pkg::DIV_DEN_W-1:0]         den,
    output logic                                  busy,
    output logic                                  done,
    output logic signed [khi_pkg::DIV_QUO_W-1:0]  quo
);
    import khi_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_NUM_W-1:0] work_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic                 neg_reg;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;
    logic [DIV_DEN_W-1:0] rem_next;
    logic [DIV_NUM_W-1:0] work_next;

    // restoring step: one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, work_reg[DIV_NUM_W-1]};
        fits      = trial >= {1'b0, den_reg};
        rem_next  = fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
        work_next = {work_reg[DIV_NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_NUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // bias by half the divisor so the floor quotient rounds to nearest
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= num_mag + DIV_NUM_W'(den >> 1);
            rem_reg  <= '0;
            den_reg  <= den;
            neg_reg  <= neg;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = neg_reg ? -$signed({1'b0, work_reg}) : $signed({1'b0, work_reg});

endmodule

/* hw/rtl/khi_datapath.sv */
module khi_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  khi_pkg::khi_cmd_t cmd,
    output khi_pkg::khi_stat_t stat,
    input  khi_pkg::khi_in_t  in_data,
    input  logic              out_ready,
    output logic              out_valid,
    output khi_pkg::khi_out_t out_data
);
    import khi_pkg::*;

    localparam logic signed [51:0] ONE48  = 52'sd1 <<< 48;
    localparam logic signed [75:0] HALF25 = 76'sd1 <<< 24;
    localparam logic signed [50:0] SAT_HI = 51'sd2147483647;
    localparam logic signed [50:0] SAT_LO = -51'sd2147483648;

    function automatic logic signed [17:0] round_sh32(input logic signed [51:0] n);
        logic [51:0] mag;
        logic [51:0] r;
        mag = n[51] ? 52'(-n) : 52'(n);
        r   = (mag + 52'h8000_0000) >> 32;
        return n[51] ? -$signed(r[17:0]) : $signed(r[17:0]);
    endfunction

    khi_in_t              req_reg;
    logic [KF_CNT_W-1:0]  count_reg;
    logic [15:0]          first_reg;
    logic [15:0]          last_reg;
    khi_entry_t           mem [KF_MAX];
    khi_entry_t           mem_rdata_reg;
    logic [KF_IDX_W-1:0]  idx_reg;
    logic [1:0]           ld_slot_reg;
    khi_entry_t           ent_reg [4];
    logic [16:0]          t_reg;
    logic [33:0]          t2_reg;
    logic [48:0]          t3_reg;
    logic signed [17:0]   h00_reg, h10_reg, h01_reg, h11_reg;
    logic signed [49:0]   side_prod_reg;
    logic signed [57:0]   qab_reg, qcd_reg;
    logic signed [58:0]   m0_reg, m1_reg;
    logic [2:0]           term_reg;
    logic signed [50:0]   prod_reg;
    logic signed [75:0]   acc_reg;
    logic [CH_IDX_W-1:0]  ch_reg;
    logic [1:0]           res_status_reg;
    logic [31:0]          res_reg [NUM_CH];
    logic                 out_valid_reg;
    khi_out_t             out_data_reg;

    logic [KF_CNT_W-1:0]  cnt_m1, cnt_m2;
    logic                 app_new, app_rep, full, mem_we;
    logic [KF_IDX_W-1:0]  wa;
    khi_entry_t           wentry;
    logic [KF_CNT_W:0]    ld_sum, next_sum;
    logic                 has_prev, has_next, slot_ok, rd_en;
    logic [KF_IDX_W-1:0]  rd_addr;
    logic [15:0]          seg, u;
    logic signed [32:0]   ya, yb, yc, yd, dy_side;
    logic signed [16:0]   seg_s;
    logic signed [49:0]   side_prod_next;
    logic [49:0]          side_abs;
    logic                 div_start, div_neg, div_busy, div_done;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic signed [DIV_QUO_W-1:0] div_quo;
    logic signed [51:0]   t3s, t2s16, ts32, n00, n10, n01, n11;
    logic signed [40:0]   qbc;
    logic signed [17:0]   h_sel;
    logic signed [32:0]   x_sel;
    logic signed [75:0]   acc_add;
    logic signed [75:0]   acc_round;
    logic signed [50:0]   vres;
    logic [31:0]          ch_val;

    // ---------------- keyframe table bookkeeping ----------------
    always_comb
    begin
        cnt_m1  = count_reg - KF_CNT_W'(1);
        cnt_m2  = count_reg - KF_CNT_W'(2);
        app_new = (count_reg == '0) || (req_reg.frame_number > last_reg);
        app_rep = (count_reg != '0) && (req_reg.frame_number == last_reg);
        full    = count_reg >= KF_CNT_W'(KF_MAX);
        mem_we  = cmd.append && ((app_new && !full) || app_rep);
        wa      = app_new ? count_reg[KF_IDX_W-1:0] : cnt_m1[KF_IDX_W-1:0];
        wentry.frame  = req_reg.frame_number;
        wentry.ch[0]  = req_reg.fov_value;
        wentry.ch[1]  = req_reg.pos_x;
        wentry.ch[2]  = req_reg.pos_y;
        wentry.ch[3]  = req_reg.pos_z;
        wentry.ch[4]  = req_reg.rot_pitch;
        wentry.ch[5]  = req_reg.rot_yaw;
        wentry.ch[6]  = req_reg.rot_roll;
    end

    always_comb
    begin
        has_prev = idx_reg != '0;
        next_sum = (KF_CNT_W + 1)'(idx_reg) + (KF_CNT_W + 1)'(2);
        has_next = next_sum < (KF_CNT_W + 1)'(count_reg);
        ld_sum   = (KF_CNT_W + 1)'(idx_reg) + (KF_CNT_W + 1)'(ld_slot_reg)
                 - (KF_CNT_W + 1)'(1);
        case (ld_slot_reg)
            2'd0:    slot_ok = has_prev;
            2'd3:    slot_ok = has_next;
            default: slot_ok = 1'b1;
        endcase
        rd_en = cmd.rd_last || cmd.rd_idx || (cmd.ld_rd && slot_ok);
        if (cmd.rd_last)
            rd_addr = cnt_m1[KF_IDX_W-1:0];
        else if (cmd.rd_idx)
            rd_addr = idx_reg;
        else
            rd_addr = ld_sum[KF_IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wa] <= wentry;
        if (rd_en)
            mem_rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.clear)
            count_reg <= '0;
        else if (cmd.append && app_new && !full)
            count_reg <= count_reg + KF_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= in_data;
        if (cmd.append && app_new && !full)
        begin
            last_reg <= req_reg.frame_number;
            if (count_reg == '0)
                first_reg <= req_reg.frame_number;
        end
    end

    // ---------------- segment search and neighbor load ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.idx_init)
            idx_reg <= cnt_m2[KF_IDX_W-1:0];
        else if (cmd.idx_dec)
            idx_reg <= idx_reg - KF_IDX_W'(1);
        if (cmd.ld_init)
            ld_slot_reg <= 2'd0;
        else if (cmd.ld_wr)
        begin
            ld_slot_reg <= ld_slot_reg + 2'd1;
            if (slot_ok)
                ent_reg[ld_slot_reg] <= mem_rdata_reg;
        end
    end

    // ---------------- shared divider ----------------
    always_comb
    begin
        seg     = ent_reg[2].frame - ent_reg[1].frame;
        u       = req_reg.frame_number - ent_reg[1].frame;
        ya      = 33'($signed(ent_reg[0].ch[ch_reg]));
        yb      = 33'($signed(ent_reg[1].ch[ch_reg]));
        yc      = 33'($signed(ent_reg[2].ch[ch_reg]));
        yd      = 33'($signed(ent_reg[3].ch[ch_reg]));
        dy_side = (cmd.side == SIDE_A) ? (yb - ya) : (yd - yc);
        seg_s   = $signed({1'b0, seg});
        side_prod_next = dy_side * seg_s;
        side_abs = side_prod_reg[49] ? 50'(-side_prod_reg) : 50'(side_prod_reg);
        div_start = cmd.div_start;
        if (cmd.div_src == DIV_T)
        begin
            div_num = DIV_NUM_W'({u, 16'h0000});
            div_neg = 1'b0;
            div_den = seg;
        end
        else
        begin
            div_num = {side_abs[48:0], 8'h00};
            div_neg = side_prod_reg[49];
            div_den = (cmd.side == SIDE_A) ? (ent_reg[1].frame - ent_reg[0].frame)
                                           : (ent_reg[3].frame - ent_reg[2].frame);
        end
    end

    khi_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag (div_num),
        .neg     (div_neg),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_quo)
    );

    // ---------------- Hermite basis ----------------
    always_comb
    begin
        t3s   = $signed({3'b000, t3_reg});
        t2s16 = $signed({2'b00, t2_reg, 16'h0000});
        ts32  = $signed({3'b000, t_reg, 32'h0000_0000});
        n00   = (t3s <<< 1) - (t2s16 + (t2s16 <<< 1)) + ONE48;
        n10   = t3s - (t2s16 <<< 1) + ts32;
        n01   = (t2s16 + (t2s16 <<< 1)) - (t3s <<< 1);
        n11   = t3s - t2s16;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.t_load)
            t_reg <= div_quo[16:0];
        if (cmd.t2_load)
            t2_reg <= 34'(t_reg) * 34'(t_reg);
        if (cmd.t3_load)
            t3_reg <= 49'(t2_reg[32:0]) * 49'(t_reg);
        if (cmd.h_load)
        begin
            h00_reg <= round_sh32(n00);
            h10_reg <= round_sh32(n10);
            h01_reg <= round_sh32(n01);
            h11_reg <= round_sh32(n11);
        end
    end

    // ---------------- tangents and weighted sum ----------------
    always_comb
    begin
        qbc = $signed({yc - yb, 8'h00});
        case (term_reg)
            3'd0:
            begin
                h_sel = h00_reg;
                x_sel = yb;
            end
            3'd1:
            begin
                h_sel = h01_reg;
                x_sel = yc;
            end
            3'd2:
            begin
                h_sel = h10_reg;
                x_sel = $signed({1'b0, m0_reg[31:0]});
            end
            3'd3:
            begin
                h_sel = h10_reg;
                x_sel = 33'($signed(m0_reg[58:32]));
            end
            3'd4:
            begin
                h_sel = h11_reg;
                x_sel = $signed({1'b0, m1_reg[31:0]});
            end
            default:
            begin
                h_sel = h11_reg;
                x_sel = 33'($signed(m1_reg[58:32]));
            end
        endcase
        case (term_reg) inside
            3'd0, 3'd1: acc_add = 76'(prod_reg) <<< 9;
            3'd2, 3'd4: acc_add = 76'(prod_reg);
            default:    acc_add = 76'(prod_reg) <<< 32;
        endcase
        acc_round = acc_reg + HALF25;
        vres      = acc_round[75:25];
        if (ch_reg >= CH_IDX_W'(CH_ROT0))
            ch_val = vres[31:0];
        else if (vres > SAT_HI)
            ch_val = SAT_HI[31:0];
        else if (vres < SAT_LO)
            ch_val = SAT_LO[31:0];
        else
            ch_val = vres[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.side_mul)
            side_prod_reg <= side_prod_next;
        if (cmd.q_load)
        begin
            if (cmd.side == SIDE_A)
                qab_reg <= div_quo;
            else
                qcd_reg <= div_quo;
        end
        if (cmd.m_load)
        begin
            m0_reg <= has_prev ? (59'(qab_reg) + 59'(qbc)) : (59'(qbc) <<< 1);
            m1_reg <= has_next ? (59'(qcd_reg) + 59'(qbc)) : (59'(qbc) <<< 1);
        end
        if (cmd.mac_clr)
        begin
            acc_reg  <= '0;
            term_reg <= 3'd0;
        end
        else if (cmd.mac_acc)
        begin
            acc_reg  <= acc_reg + acc_add;
            term_reg <= term_reg + 3'd1;
        end
        if (cmd.mac_mul)
            prod_reg <= h_sel * x_sel;
    end

    // ---------------- result and output register ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.res_zero)
        begin
            res_status_reg <= ST_NONE;
            for (int c = 0; c < NUM_CH; c++)
                res_reg[c] <= '0;
        end
        else if (cmd.res_hold)
        begin
            res_status_reg <= ST_HELD;
            for (int c = 0; c < NUM_CH; c++)
                res_reg[c] <= mem_rdata_reg.ch[c];
        end
        else if (cmd.ch_init)
            res_status_reg <= ST_INTERP;
        if (cmd.ch_store)
            res_reg[ch_reg] <= ch_val;
        if (cmd.ch_init)
            ch_reg <= '0;
        else if (cmd.ch_next)
            ch_reg <= ch_reg + CH_IDX_W'(1);
        if (cmd.out_load)
        begin
            out_data_reg.status    <= res_status_reg;
            out_data_reg.out_fov   <= res_reg[0];
            out_data_reg.out_pos_x <= res_reg[1];
            out_data_reg.out_pos_y <= res_reg[2];
            out_data_reg.out_pos_z <= res_reg[3];
            out_data_reg.out_pitch <= res_reg[4][23:8];
            out_data_reg.out_yaw   <= res_reg[5][23:8];
            out_data_reg.out_roll  <= res_reg[6][23:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        stat.act      = req_reg.action;
        stat.q_zero   = (count_reg == '0)
                     || ((count_reg > KF_CNT_W'(1)) && (req_reg.frame_number < first_reg));
        stat.q_hold   = (count_reg == KF_CNT_W'(1)) || (req_reg.frame_number >= last_reg);
        stat.idx_stop = (idx_reg == '0) || !(mem_rdata_reg.frame > req_reg.frame_number);
        stat.ld_last  = ld_slot_reg == 2'd3;
        stat.has_prev = has_prev;
        stat.has_next = has_next;
        stat.div_done = div_done;
        stat.mac_last = term_reg == 3'd5;
        stat.ch_last  = ch_reg == CH_IDX_W'(NUM_CH - 1);
        stat.out_free = !out_valid_reg || out_ready;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= KF_CNT_W'(KF_MAX))
        else $error("keyframe count above table depth");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwrote a pending output");

    a_first_key: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.append && count_reg == '0) |=> (count_reg == KF_CNT_W'(1)
                                            && first_reg == last_reg))
        else $error("first append did not set bounds");

endmodule

/* hw/rtl/khi_ctrl.sv */
module khi_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  khi_pkg::khi_stat_t stat,
    output khi_pkg::khi_cmd_t  cmd
);
    import khi_pkg::*;

    khi_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.act)
                    ACT_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    ACT_APPEND:
                    begin
                        cmd.append = 1'b1;
                        state_next = S_IDLE;
                    end
                    ACT_QUERY:
                    begin
                        if (stat.q_zero)
                        begin
                            cmd.res_zero = 1'b1;
                            state_next   = S_FINISH;
                        end
                        else if (stat.q_hold)
                            state_next = S_HOLD_RD;
                        else
                        begin
                            cmd.idx_init = 1'b1;
                            state_next   = S_SRCH_RD;
                        end
                    end
                    ACT_NOP:
                        state_next = S_IDLE;
                endcase
            end
            S_HOLD_RD:
            begin
                cmd.rd_last = 1'b1;
                state_next  = S_HOLD_WR;
            end
            S_HOLD_WR:
            begin
                cmd.res_hold = 1'b1;
                state_next   = S_FINISH;
            end
            S_SRCH_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_SRCH_CHK;
            end
            S_SRCH_CHK:
            begin
                if (stat.idx_stop)
                begin
                    cmd.ld_init = 1'b1;
                    state_next  = S_LD_RD;
                end
                else
                begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_SRCH_RD;
                end
            end
            S_LD_RD:
            begin
                cmd.ld_rd  = 1'b1;
                state_next = S_LD_WR;
            end
            S_LD_WR:
            begin
                cmd.ld_wr  = 1'b1;
                state_next = stat.ld_last ? S_T_DIV : S_LD_RD;
            end
            S_T_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DIV_T;
                state_next    = S_T_WAIT;
            end
            S_T_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.t_load = 1'b1;
                    state_next = S_BAS_T2;
                end
            end
            S_BAS_T2:
            begin
                cmd.t2_load = 1'b1;
                state_next  = S_BAS_T3;
            end
            S_BAS_T3:
            begin
                cmd.t3_load = 1'b1;
                state_next  = S_BAS_H;
            end
            S_BAS_H:
            begin
                cmd.h_load  = 1'b1;
                cmd.ch_init = 1'b1;
                state_next  = S_A_MUL;
            end
            S_A_MUL:
            begin
                cmd.side = SIDE_A;
                if (stat.has_prev)
                begin
                    cmd.side_mul = 1'b1;
                    state_next   = S_A_DIV;
                end
                else
                    state_next = S_D_MUL;
            end
            S_A_DIV:
            begin
                cmd.side      = SIDE_A;
                cmd.div_src   = DIV_SIDE;
                cmd.div_start = 1'b1;
                state_next    = S_A_WAIT;
            end
            S_A_WAIT:
            begin
                cmd.side = SIDE_A;
                if (stat.div_done)
                begin
                    cmd.q_load = 1'b1;
                    state_next = S_D_MUL;
                end
            end
            S_D_MUL:
            begin
                cmd.side = SIDE_D;
                if (stat.has_next)
                begin
                    cmd.side_mul = 1'b1;
                    state_next   = S_D_DIV;
                end
                else
                    state_next = S_M_CALC;
            end
            S_D_DIV:
            begin
                cmd.side      = SIDE_D;
                cmd.div_src   = DIV_SIDE;
                cmd.div_start = 1'b1;
                state_next    = S_D_WAIT;
            end
            S_D_WAIT:
            begin
                cmd.side = SIDE_D;
                if (stat.div_done)
                begin
                    cmd.q_load = 1'b1;
                    state_next = S_M_CALC;
                end
            end
            S_M_CALC:
            begin
                cmd.m_load  = 1'b1;
                cmd.mac_clr = 1'b1;
                state_next  = S_MAC_MUL;
            end
            S_MAC_MUL:
            begin
                cmd.mac_mul = 1'b1;
                state_next  = S_MAC_ACC;
            end
            S_MAC_ACC:
            begin
                cmd.mac_acc = 1'b1;
                state_next  = stat.mac_last ? S_CH_STORE : S_MAC_MUL;
            end
            S_CH_STORE:
            begin
                cmd.ch_store = 1'b1;
                if (stat.ch_last)
                    state_next = S_FINISH;
                else
                begin
                    cmd.ch_next = 1'b1;
                    state_next  = S_A_MUL;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

/* hw/rtl/keyframe_hermite_interpolator_unit.sv */
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-------------------------------
// in       | input     | in_valid / in_ready    | in_data  (khi_pkg::khi_in_t)
// out      | output    | out_valid / out_ready  | out_data (khi_pkg::khi_out_t)
//
// Clear, append and no-op requests give no result; an empty query returns
// status none and a held query returns the last stored keyframe. An
// interpolating query searches the segment in at most count-2 steps, loads
// the neighbors, divides once for t and then, per channel, once per outer
// neighbor side (0 to 2) on the bit-serial divider.
// rst_n clears the keyframe count, controller state and output valid; the
// table itself is not cleared. A finished result waits in the output register,
// and a new request is taken meanwhile; the next result holds until it drains.
module keyframe_hermite_interpolator_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  khi_pkg::khi_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output khi_pkg::khi_out_t out_data
);
    import khi_pkg::*;

    // controller drives datapath commands and reads back status flags
    khi_cmd_t  cmd;
    khi_stat_t stat;

    // sequence one request at a time: decode, search, load, divide, accumulate
    khi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // hold the table, the basis and tangent math, and the output register
    khi_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
